@@ rtl/core/mpp_pkg.sv @@
// shared constants, widths, codes and controller/datapath interface types
// for the monochrome page pixel packer; no dependencies
package mpp_pkg;

	// frame store geometry
	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int PAGES_MAX   = MAX_ROWS / 8;
	localparam int STORE_SIZE  = MAX_COLUMNS * PAGES_MAX;
	localparam int ADDR_W      = $clog2(STORE_SIZE);
	localparam int DI_W        = $clog2(STORE_SIZE);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int PAGE_W      = (PAGES_MAX > 1) ? $clog2(PAGES_MAX) : 1;

	// field and register widths
	localparam int COLUMN_W   = 7;
	localparam int ROW_W      = 6;
	localparam int PIX_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_COL_W  = 8;
	localparam int CFG_ROW_W  = 7;
	localparam int PG_W       = CFG_ROW_W - 3;
	localparam int TOT_W      = CFG_COL_W + PG_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_CNT_W  = $clog2(DI_W);

	// item actions
	localparam logic ACT_STORE = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;

	localparam logic [CFG_COL_W-1:0] COLS_RESET = 8'd128;
	localparam logic [CFG_ROW_W-1:0] ROWS_RESET = 7'd64;

	typedef struct packed {
		logic latch;      // capture accepted item
		logic st_read;    // read store entry of the item
		logic st_write;   // write back modified entry
		logic dr_empty;   // empty frame: emit 0 with last flag
		logic dr_zero;    // restart drain position
		logic div_start;  // recompute column/page from drain index
		logic div_load;   // take divider results
		logic dr_read;    // read entry at drain position
		logic dr_out;     // load output register and advance
	} mpp_cmd_t;

	typedef struct packed {
		logic in_range;   // latched store item lies inside the frame
		logic empty;      // no columns or no pages in use
		logic stale;      // drain index at or past frame size
		logic dirty;      // position counters out of date after a config write
		logic div_done;
		logic out_busy;   // output register holds an item
	} mpp_sts_t;

endpackage

@@ rtl/core/mpp_div.sv @@
// restoring divider: drain index by pages in use, one quotient bit a cycle
// depends on mpp_pkg
module mpp_div
	import mpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DI_W-1:0]   dividend,
	input  logic [PG_W-1:0]   divisor,
	output logic              done,
	output logic [DI_W-1:0]   quotient,
	output logic [PG_W-1:0]   remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DI_W-1:0]      quo_q;
	logic [PG_W-1:0]      rem_q;
	logic [PG_W:0]        trial;
	logic                 ge;
	logic [PG_W:0]        diff;

	assign trial = {rem_q, quo_q[DI_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DI_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DI_W-2:0], ge};
			rem_q <= ge ? diff[PG_W-1:0] : trial[PG_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/mpp_datapath.sv @@
// datapath: config registers, item capture, page store, drain position
// counters and output register; depends on mpp_pkg and mpp_div
module mpp_datapath
	import mpp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpp_cmd_t              cmd,
	output mpp_sts_t              sts,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [COLUMN_W-1:0]   column,
	input  logic [ROW_W-1:0]      row,
	input  logic [PIX_W-1:0]      pixel_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     data_byte,
	output logic                  last_of_frame
);

	logic [CFG_COL_W-1:0] cols_q;
	logic [CFG_ROW_W-1:0] rows_q;
	logic                 dirty_q;
	logic [COLUMN_W-1:0]  col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 lit_q;
	logic [DI_W-1:0]      drain_index_q;
	logic [COL_W-1:0]     col_cnt_q;
	logic [PAGE_W-1:0]    page_cnt_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    data_q;
	logic                 last_q;
	logic [BYTE_W-1:0]    rd_q;
	logic [BYTE_W-1:0]    store_mem [STORE_SIZE];

	logic [CFG_COL_W-1:0] eff_cols;
	logic [PG_W-1:0]      raw_pages;
	logic [PG_W-1:0]      eff_pages;
	logic [TOT_W-1:0]     total;
	logic [2:0]           item_page;
	logic [ADDR_W-1:0]    item_addr;
	logic [ADDR_W-1:0]    drain_addr;
	logic [ADDR_W-1:0]    mem_addr;
	logic [BYTE_W-1:0]    mask;
	logic [BYTE_W-1:0]    wr_data;
	logic                 is_last;
	logic                 page_wrap;
	logic                 div_done;
	logic [DI_W-1:0]      div_quo;
	logic [PG_W-1:0]      div_rem;

	// saturate registers to the store geometry
	assign eff_cols  = (int'(cols_q) > MAX_COLUMNS) ? CFG_COL_W'(MAX_COLUMNS) : cols_q;
	assign raw_pages = rows_q[CFG_ROW_W-1:3];
	assign eff_pages = (int'(raw_pages) > PAGES_MAX) ? PG_W'(PAGES_MAX) : raw_pages;
	assign total     = TOT_W'(eff_cols) * TOT_W'(eff_pages);

	assign item_page  = row_q[ROW_W-1:3];
	assign item_addr  = ADDR_W'(int'(col_q) * PAGES_MAX) + ADDR_W'(item_page);
	assign drain_addr = ADDR_W'(int'(col_cnt_q) * PAGES_MAX) + ADDR_W'(page_cnt_q);
	assign mem_addr   = cmd.dr_read ? drain_addr : item_addr;
	assign mask       = BYTE_W'(1) << row_q[2:0];
	assign wr_data    = lit_q ? (rd_q | mask) : (rd_q & ~mask);

	assign is_last   = (TOT_W'(drain_index_q) + TOT_W'(1)) == total;
	assign page_wrap = ((PG_W+1)'(page_cnt_q) + (PG_W+1)'(1)) == (PG_W+1)'(eff_pages);

	mpp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (drain_index_q),
		.divisor   (eff_pages),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		sts.in_range = (CFG_COL_W'(col_q) < eff_cols) && (PG_W'(item_page) < eff_pages);
		sts.empty    = (eff_cols == '0) || (eff_pages == '0);
		sts.stale    = TOT_W'(drain_index_q) >= total;
		sts.dirty    = dirty_q;
		sts.div_done = div_done;
		sts.out_busy = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q        <= COLS_RESET;
			rows_q        <= ROWS_RESET;
			dirty_q       <= 1'b0;
			drain_index_q <= '0;
			col_cnt_q     <= '0;
			page_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				if (cfg_index == CFG_COLUMNS) begin
					cols_q <= cfg_data;
				end
				if (cfg_index == CFG_ROWS) begin
					rows_q <= cfg_data[CFG_ROW_W-1:0];
				end
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.dr_empty || cmd.dr_zero) begin
				drain_index_q <= '0;
				col_cnt_q     <= '0;
				page_cnt_q    <= '0;
			end else if (cmd.div_load) begin
				col_cnt_q  <= div_quo[COL_W-1:0];
				page_cnt_q <= div_rem[PAGE_W-1:0];
			end else if (cmd.dr_out) begin
				if (is_last) begin
					drain_index_q <= '0;
					col_cnt_q     <= '0;
					page_cnt_q    <= '0;
				end else begin
					drain_index_q <= drain_index_q + 1'b1;
					if (page_wrap) begin
						page_cnt_q <= '0;
						col_cnt_q  <= col_cnt_q + 1'b1;
					end else begin
						page_cnt_q <= page_cnt_q + 1'b1;
					end
				end
			end

			if (cmd.dr_empty || cmd.dr_out) begin
				out_valid_q <= 1'b1;
			end

			if (cfg_write_en) begin
				dirty_q <= 1'b1;
			end else if (cmd.dr_empty || cmd.dr_zero || cmd.div_load) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			col_q <= column;
			row_q <= row;
			lit_q <= pixel_value != '0;
		end
		if (cmd.dr_empty) begin
			data_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.dr_out) begin
			data_q <= rd_q;
			last_q <= is_last;
		end
	end

	// single-port page store, registered read
	always_ff @(posedge clk) begin
		if (cmd.st_write) begin
			store_mem[mem_addr] <= wr_data;
		end
		if (cmd.st_read || cmd.dr_read) begin
			rd_q <= store_mem[mem_addr];
		end
	end

	assign out_valid     = out_valid_q;
	assign data_byte     = data_q;
	assign last_of_frame = last_q;

endmodule

@@ rtl/core/mpp_ctrl.sv @@
// controller state machine: input handshake and sequencing of store
// read-modify-write and drain steps; depends on mpp_pkg
module mpp_ctrl
	import mpp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     action,
	input  logic     out_ready,
	input  mpp_sts_t sts,
	output mpp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ST_RD  = 3'd1;
	localparam logic [2:0] S_ST_WR  = 3'd2;
	localparam logic [2:0] S_DR_CHK = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_DR_RD  = 3'd5;
	localparam logic [2:0] S_DR_OUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	// a drain needs the output register free, or freed this cycle
	assign in_ready = (state_q == S_IDLE)
		&& ((action == ACT_STORE) || !sts.out_busy || out_ready);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = accept;
				if (accept) begin
					state_d = (action == ACT_DRAIN) ? S_DR_CHK : S_ST_RD;
				end
			end
			S_ST_RD: begin
				if (sts.in_range) begin
					cmd.st_read = 1'b1;
					state_d     = S_ST_WR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ST_WR: begin
				cmd.st_write = 1'b1;
				state_d      = S_IDLE;
			end
			S_DR_CHK: begin
				priority if (sts.empty) begin
					cmd.dr_empty = 1'b1;
					state_d      = S_IDLE;
				end else if (sts.stale) begin
					cmd.dr_zero = 1'b1;
					state_d     = S_DR_RD;
				end else if (sts.dirty) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_DR_RD;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_load = 1'b1;
					state_d      = S_DR_RD;
				end
			end
			S_DR_RD: begin
				cmd.dr_read = 1'b1;
				state_d     = S_DR_OUT;
			end
			S_DR_OUT: begin
				cmd.dr_out = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/mono_page_pixel_packer_core.sv @@
// top level of the monochrome page pixel packer: controller plus datapath
// depends on mpp_pkg, mpp_ctrl, mpp_datapath
//
// Packs 16-bit pixels into 1-bit-per-pixel bytes in vertical page order and
// drains them column by column, all pages of a column first. The page store
// is a single-port memory with a registered read, so each item is handled
// in turn: a store item is accepted, read and written back, or only accepted
// if its pixel is outside the frame; a drain item is accepted, checked, read
// and loaded into the output register. The first drain after a register
// write, unless the frame is empty or the drain index is at or past its end,
// re-derives column and page from that index with a restoring divider, one
// bit per cycle. A new store item is taken while a drained byte waits in the
// output register; a new drain item waits until that register is taken. No
// clearing pass runs after reset: bytes never stored read back undefined.
module mono_page_pixel_packer_core
	import mpp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [COLUMN_W-1:0]   column,
	input  logic [ROW_W-1:0]      row,
	input  logic [PIX_W-1:0]      pixel_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     data_byte,
	output logic                  last_of_frame,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mpp_cmd_t cmd;
	mpp_sts_t sts;

	mpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.column        (column),
		.row           (row),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame)
	);

endmodule
